>>> hw/rtl/ffd_pkg.sv
`default_nettype none

package ffd_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_KEY_TEXT    = 2'd0;
	localparam logic [1:0] REG_KEY_LENGTH  = 2'd1;
	localparam logic [1:0] REG_VALUE_LIMIT = 2'd2;

	localparam logic [63:0] KEY_TEXT_RST    = 64'd0;
	localparam logic [3:0]  KEY_LENGTH_RST  = 4'd4;
	localparam logic [6:0]  VALUE_LIMIT_RST = 7'd32;

	// characters with a meaning in a form body
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int RES_SLOTS = 4;

	typedef struct packed {
		logic [63:0] key_text;
		logic [3:0]  key_length;
		logic [6:0]  value_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] value_byte;
		logic       byte_valid;
		logic       value_done;
		logic       field_found;
	} res_t;

	typedef struct packed {
		res_t [RES_SLOTS-1:0] items;
		logic [2:0]           count;
	} bundle_t;

endpackage

`default_nettype wire

>>> hw/rtl/ffd_in_if.sv
`default_nettype none

interface ffd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;
	logic       body_end;

	modport source (output valid, output body_byte, output body_end, input ready);
	modport sink (input valid, input body_byte, input body_end, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ffd_out_if.sv
`default_nettype none

interface ffd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] value_byte;
	logic       byte_valid;
	logic       value_done;
	logic       field_found;

	modport source (output valid, output value_byte, output byte_valid,
		output value_done, output field_found, input ready);
	modport sink (input valid, input value_byte, input byte_valid,
		input value_done, input field_found, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/ffd_parse.sv
`default_nettype none

module ffd_parse
	import ffd_pkg::*;
#(
	parameter int KEY_BYTES  = 8,
	parameter int RAW_BUFFER = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] body_byte,
	input  wire logic       body_end,
	input  wire cfg_t       cfg,
	output bundle_t         bundle
);

	localparam int KP_W  = $clog2(KEY_BYTES + 1);
	localparam int RAW_W = $clog2(RAW_BUFFER);

	localparam logic [1:0] PH_MATCH = 2'd0;
	localparam logic [1:0] PH_SKIP  = 2'd1;
	localparam logic [1:0] PH_VALUE = 2'd2;
	localparam logic [1:0] PH_AFTER = 2'd3;

	logic [1:0]       phase_q, phase_n;
	logic [KP_W-1:0]  kpos_q, kpos_n;
	logic [1:0]       held_cnt_q, held_cnt_n;
	logic [7:0]       held_hi_q, held_hi_n;
	logic [RAW_W-1:0] raw_q, raw_n;
	logic [6:0]       out_q, out_n;
	logic             found_q, found_n;

	logic [KP_W-1:0] klen;
	logic [7:0]      key_sel;
	logic [7:0]      pre_c [3];
	logic [1:0]      pre_n;
	logic [7:0]      cand [3];
	logic [1:0]      cnum;
	logic [1:0]      emit_n;
	logic [6:0]      room;
	logic            flush;
	logic            is_amp;
	logic            fr_hold;
	logic [7:0]      fr_char;
	logic            hx_ok;
	logic [3:0]      hx_val;
	logic [3:0]      hi_val;

	// hex digit: {is digit, value}
	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	assign klen    = (cfg.key_length > 4'(KEY_BYTES)) ? KP_W'(KEY_BYTES) : KP_W'(cfg.key_length);
	assign key_sel = 8'(cfg.key_text >> {kpos_q, 3'b000});
	assign is_amp  = (body_byte == CH_AMP);
	assign fr_hold = (body_byte == CH_PCT);
	assign fr_char = (body_byte == CH_PLUS) ? CH_SPACE : body_byte;
	assign {hx_ok, hx_val} = hex_of(body_byte);
	assign hi_val  = 4'(hex_of(held_hi_q));

	always_comb begin
		phase_n    = phase_q;
		kpos_n     = kpos_q;
		held_cnt_n = held_cnt_q;
		held_hi_n  = held_hi_q;
		raw_n      = raw_q;
		found_n    = found_q;
		pre_n      = 2'd0;
		pre_c[0]   = 8'd0;
		pre_c[1]   = 8'd0;
		pre_c[2]   = 8'd0;
		flush      = 1'b0;

		unique case (phase_q)
			PH_MATCH: begin
				if (is_amp) begin
					kpos_n = '0;
				end else if (kpos_q < klen && body_byte == key_sel) begin
					kpos_n = kpos_q + KP_W'(1);
				end else if (kpos_q == klen && body_byte == CH_EQ) begin
					found_n = 1'b1;
					phase_n = PH_VALUE;
				end else begin
					phase_n = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (is_amp) begin
					phase_n = PH_MATCH;
					kpos_n  = '0;
				end
			end
			PH_VALUE: begin
				if (is_amp) begin
					flush   = 1'b1;
					phase_n = PH_AFTER;
				end else begin
					raw_n = raw_q + RAW_W'(1);
					case (held_cnt_q)
						2'd0: begin
							if (fr_hold) begin
								held_cnt_n = 2'd1;
							end else begin
								pre_c[0] = fr_char;
								pre_n    = 2'd1;
							end
						end
						2'd1: begin
							if (hx_ok) begin
								held_cnt_n = 2'd2;
								held_hi_n  = body_byte;
							end else begin
								pre_c[0] = CH_PCT;
								if (fr_hold) begin
									held_cnt_n = 2'd1;
									pre_n      = 2'd1;
								end else begin
									held_cnt_n = 2'd0;
									pre_c[1]   = fr_char;
									pre_n      = 2'd2;
								end
							end
						end
						default: begin
							held_cnt_n = 2'd0;
							if (hx_ok) begin
								pre_c[0] = {hi_val, hx_val};
								pre_n    = 2'd1;
							end else begin
								pre_c[0] = CH_PCT;
								pre_c[1] = held_hi_q;
								if (fr_hold) begin
									held_cnt_n = 2'd1;
									pre_n      = 2'd2;
								end else begin
									pre_c[2] = fr_char;
									pre_n    = 2'd3;
								end
							end
						end
					endcase
					// raw value full: rest of the body is ignored
					if (raw_n >= RAW_W'(RAW_BUFFER - 1)) begin
						flush   = 1'b1;
						phase_n = PH_AFTER;
					end
				end
			end
			default: begin
			end
		endcase

		if (body_end && phase_n == PH_VALUE)
			flush = 1'b1;

		// decoded candidates: value bytes first, then any flushed escape
		cnum = pre_n + (flush ? held_cnt_n : 2'd0);
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < pre_n)
				cand[i] = pre_c[i];
			else if (2'(i) == pre_n)
				cand[i] = CH_PCT;
			else
				cand[i] = held_hi_n;
		end
		if (flush)
			held_cnt_n = 2'd0;

		// bytes past the limit are dropped
		room   = (cfg.value_limit > out_q) ? (cfg.value_limit - out_q) : 7'd0;
		emit_n = (7'(cnum) < room) ? cnum : room[1:0];
		out_n  = out_q + 7'(emit_n);

		for (int i = 0; i < 3; i++) begin
			if (2'(i) < emit_n)
				bundle.items[i] = '{value_byte: cand[i], byte_valid: 1'b1,
					value_done: 1'b0, field_found: 1'b0};
			else
				bundle.items[i] = '{value_byte: 8'd0, byte_valid: 1'b0,
					value_done: 1'b1, field_found: found_n};
		end
		bundle.items[3] = '{value_byte: 8'd0, byte_valid: 1'b0,
			value_done: 1'b1, field_found: found_n};
		bundle.count = 3'(emit_n) + 3'(body_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_MATCH;
			kpos_q     <= '0;
			held_cnt_q <= 2'd0;
			held_hi_q  <= 8'd0;
			raw_q      <= '0;
			out_q      <= 7'd0;
			found_q    <= 1'b0;
		end else if (advance) begin
			if (body_end) begin
				phase_q    <= PH_MATCH;
				kpos_q     <= '0;
				held_cnt_q <= 2'd0;
				held_hi_q  <= 8'd0;
				raw_q      <= '0;
				out_q      <= 7'd0;
				found_q    <= 1'b0;
			end else begin
				phase_q    <= phase_n;
				kpos_q     <= kpos_n;
				held_cnt_q <= held_cnt_n;
				held_hi_q  <= held_hi_n;
				raw_q      <= raw_n;
				out_q      <= out_n;
				found_q    <= found_n;
			end
		end
	end

	// an escape is held only while a value is being decoded
	a_held_only_in_value: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_VALUE) |-> (held_cnt_q == 2'd0))
		else $error("escape held outside value phase");

	// the key position never runs past the key
	a_kpos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_MATCH && advance && !body_end && !is_amp) |=> (kpos_q <= $past(klen)))
		else $error("key position past key length");

endmodule

`default_nettype wire

>>> hw/rtl/ffd_out_buf.sv
`default_nettype none

module ffd_out_buf
	import ffd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire bundle_t  bundle,
	output logic          can_take,
	ffd_out_if.source     value
);

	res_t [RES_SLOTS-1:0] items_s2;
	logic [2:0]           cnt_s2;
	logic [1:0]           idx_q;
	logic                 busy_q;
	logic                 fire;
	logic                 last_out;
	res_t                 cur;

	assign cur               = items_s2[idx_q];
	assign value.valid       = busy_q;
	assign value.value_byte  = cur.value_byte;
	assign value.byte_valid  = cur.byte_valid;
	assign value.value_done  = cur.value_done;
	assign value.field_found = cur.field_found;

	assign fire     = busy_q && value.ready;
	assign last_out = ((3'(idx_q) + 3'd1) == cnt_s2);
	assign can_take = !busy_q || (fire && last_out);

	always_ff @(posedge clk) begin
		if (push)
			items_s2 <= bundle.items;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
			cnt_s2 <= 3'd0;
		end else if (push) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
			cnt_s2 <= bundle.count;
		end else if (fire) begin
			if (last_out)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	a_push_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (can_take && bundle.count != 3'd0))
		else $error("bundle loaded over pending results");

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (3'(idx_q) < cnt_s2))
		else $error("result index beyond bundle count");

endmodule

`default_nettype wire

>>> hw/rtl/form_field_extract_decode_top.sv
// channel  dir  signals                                   transfer when
// body     in   valid ready body_byte[7:0] body_end       valid & ready
// value    out  valid ready value_byte[7:0] byte_valid    valid & ready
//               value_done field_found
// wr       in   wr_en wr_index[1:0] wr_data[63:0]         wr_en (no handshake)
//
// one body byte per cycle when each byte yields at most one result and value is not stalled
// a byte that yields more than one result (up to 4) holds the input until the output buffer,
// which hands out one result per transfer, reaches the last result of the byte before it
// a body byte passes the input register and then the result register before its first result is offered
// arst_n clears the parse state and loads the register reset values
// stalls on value back up through the input register to body.ready
`default_nettype none

module form_field_extract_decode_top
	import ffd_pkg::*;
#(
	parameter int KEY_BYTES  = 8,
	parameter int RAW_BUFFER = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	ffd_in_if.sink           body,
	ffd_out_if.source        value,
	input  wire logic        wr_en,
	input  wire logic [1:0]  wr_index,
	input  wire logic [63:0] wr_data
);

	cfg_t       cfg_q;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	bundle_t    bundle;
	logic       can_take;
	logic       advance;
	logic       push;
	logic       in_fire;

	// configuration writes; an index past the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_text    <= KEY_TEXT_RST;
			cfg_q.key_length  <= KEY_LENGTH_RST;
			cfg_q.value_limit <= VALUE_LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_KEY_TEXT:    cfg_q.key_text    <= wr_data;
				REG_KEY_LENGTH:  cfg_q.key_length  <= wr_data[3:0];
				REG_VALUE_LIMIT: cfg_q.value_limit <= wr_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// a byte with no result retires without touching the output buffer
	assign push       = valid_s1 && (bundle.count != 3'd0) && can_take;
	assign advance    = valid_s1 && ((bundle.count == 3'd0) || can_take);
	assign body.ready = !valid_s1 || advance;
	assign in_fire    = body.valid && body.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (body.ready)
			valid_s1 <= body.valid;
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= body.body_byte;
			end_s1  <= body.body_end;
		end
	end

	// match the key, decode the value, build this byte's results
	ffd_parse #(
		.KEY_BYTES  (KEY_BYTES),
		.RAW_BUFFER (RAW_BUFFER)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.body_byte (byte_s1),
		.body_end  (end_s1),
		.cfg       (cfg_q),
		.bundle    (bundle)
	);

	// result register, hands results out one per transfer
	ffd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.bundle   (bundle),
		.can_take (can_take),
		.value    (value)
	);

	// a stalled byte stays in the input register
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1) && $stable(end_s1)))
		else $error("input register lost a stalled byte");

endmodule

`default_nettype wire

>>> dv/form_field_extract_decode_top_test.sv
`timescale 1ns / 1ps

class form_value_board;
	typedef enum logic [1:0] {SEEK_KEY, SKIP_FIELD, IN_VALUE, PAST_VALUE} scan_e;
	localparam int KEY_MAX = 8;
	localparam int RAW_MAX = 127;

	// register copies
	logic [63:0] key_text;
	logic [3:0]  key_len;
	logic [6:0]  limit;

	// parse state
	scan_e       scan;
	logic [3:0]  key_pos;
	logic [15:0] held;
	logic [1:0]  held_n;
	logic [6:0]  raw_n;
	logic [6:0]  out_n;
	logic        found;

	ffd_pkg::res_t expected_values[$];
	int unsigned   fails;

	function new();
		key_text = ffd_pkg::KEY_TEXT_RST;
		key_len  = ffd_pkg::KEY_LENGTH_RST;
		limit    = ffd_pkg::VALUE_LIMIT_RST;
		fails    = 0;
		rearm();
	endfunction

	function void set_config(logic [63:0] kt, logic [3:0] kl, logic [6:0] vl);
		key_text = kt;
		key_len  = kl;
		limit    = vl;
	endfunction

	function void rearm();
		scan    = SEEK_KEY;
		key_pos = 0;
		held    = 0;
		held_n  = 0;
		raw_n   = 0;
		out_n   = 0;
		found   = 1'b0;
	endfunction

	function int unsigned waiting();
		return expected_values.size();
	endfunction

	function int hex_val(logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return c - 8'h30;
		if (c >= 8'h61 && c <= 8'h66) return c - 8'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46) return c - 8'h41 + 10;
		return -1;
	endfunction

	// decoded byte, dropped once the limit is reached
	function void put_byte(logic [7:0] b);
		ffd_pkg::res_t r;
		if (out_n < limit) begin
			r.value_byte  = b;
			r.byte_valid  = 1'b1;
			r.value_done  = 1'b0;
			r.field_found = 1'b0;
			expected_values.push_back(r);
			out_n++;
		end
	endfunction

	function void fresh_char(logic [7:0] c);
		if (c == ffd_pkg::CH_PCT) begin
			held   = {8'h00, ffd_pkg::CH_PCT};
			held_n = 1;
		end else if (c == ffd_pkg::CH_PLUS) begin
			put_byte(ffd_pkg::CH_SPACE);
		end else begin
			put_byte(c);
		end
	endfunction

	function void flush_held();
		if (held_n >= 1) put_byte(ffd_pkg::CH_PCT);
		if (held_n >= 2) put_byte(held[15:8]);
		held   = 0;
		held_n = 0;
	endfunction

	function void decode_char(logic [7:0] c);
		int v;
		int hv;
		logic [7:0] h1;
		v = hex_val(c);
		if (held_n == 0) begin
			fresh_char(c);
		end else if (held_n == 1) begin
			if (v >= 0) begin
				held[15:8] = c;
				held_n     = 2;
			end else begin
				held   = 0;
				held_n = 0;
				put_byte(ffd_pkg::CH_PCT);
				fresh_char(c);
			end
		end else begin
			h1     = held[15:8];
			held   = 0;
			held_n = 0;
			if (v >= 0) begin
				hv = hex_val(h1);
				put_byte({hv[3:0], v[3:0]});
			end else begin
				put_byte(ffd_pkg::CH_PCT);
				put_byte(h1);
				fresh_char(c);
			end
		end
	endfunction

	// one accepted body byte
	function void note_byte(logic [7:0] b, logic last);
		logic [3:0] klen;
		ffd_pkg::res_t r;
		klen = (key_len > KEY_MAX) ? 4'(KEY_MAX) : key_len;
		case (scan)
			SEEK_KEY: begin
				if (b == ffd_pkg::CH_AMP) begin
					key_pos = 0;
				end else if (key_pos < klen && b == key_text[8*key_pos +: 8]) begin
					key_pos++;
				end else if (key_pos == klen && b == ffd_pkg::CH_EQ) begin
					found = 1'b1;
					scan  = IN_VALUE;
				end else begin
					scan = SKIP_FIELD;
				end
			end
			SKIP_FIELD: begin
				if (b == ffd_pkg::CH_AMP) begin
					scan    = SEEK_KEY;
					key_pos = 0;
				end
			end
			IN_VALUE: begin
				if (b == ffd_pkg::CH_AMP) begin
					flush_held();
					scan = PAST_VALUE;
				end else begin
					raw_n++;
					decode_char(b);
					if (raw_n >= RAW_MAX) begin
						flush_held();
						scan = PAST_VALUE;
					end
				end
			end
			default: ;
		endcase
		if (last) begin
			if (scan == IN_VALUE) flush_held();
			r.value_byte  = 8'h00;
			r.byte_valid  = 1'b0;
			r.value_done  = 1'b1;
			r.field_found = found;
			expected_values.push_back(r);
			rearm();
		end
	endfunction

	function void mismatch(string what, int unsigned want, int unsigned got);
		fails++;
		$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
	endfunction

	function void check_result(ffd_pkg::res_t got);
		ffd_pkg::res_t want;
		if (expected_values.size() == 0) begin
			fails++;
			$display("%0t: unexpected result, expected none, actual 0x%0h", $time, got);
			return;
		end
		want = expected_values.pop_front();
		if (got.value_byte !== want.value_byte)
			mismatch("value_byte", want.value_byte, got.value_byte);
		if (got.byte_valid !== want.byte_valid)
			mismatch("byte_valid", want.byte_valid, got.byte_valid);
		if (got.value_done !== want.value_done)
			mismatch("value_done", want.value_done, got.value_done);
		if (got.field_found !== want.field_found)
			mismatch("field_found", want.field_found, got.field_found);
	endfunction
endclass

module form_field_extract_decode_top_test;
	import ffd_pkg::*;

	localparam int RAND_ITEMS  = 430;  // random body bytes to send
	localparam int PHASE_BYTES = 55;   // body bytes per configuration phase
	localparam int HOLD_CYCLES = 300;  // long receiver hold-off
	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [63:0] wr_data;

	ffd_in_if  body_ch ();
	ffd_out_if value_ch ();

	form_field_extract_decode_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.body     (body_ch),
		.value    (value_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	form_value_board board;

	// idling knobs, percent of cycles
	int idle_pct;
	int stall_pct;
	// long hold-off requests, served by the receiver process
	int holds_asked;
	int holds_served;

	// register values as last written, used to shape bodies
	logic [63:0] cur_key;
	logic [3:0]  cur_len;

	// body under construction
	logic [7:0] form_bytes[$];

	int unsigned cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// transfer monitor: predict on body transfers, check on value transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (body_ch.valid && body_ch.ready)
				board.note_byte(body_ch.body_byte, body_ch.body_end);
			if (value_ch.valid && value_ch.ready)
				board.check_result({value_ch.value_byte, value_ch.byte_valid,
					value_ch.value_done, value_ch.field_found});
		end
	end

	// receiver: random stalls, plus a long hold-off when asked
	initial begin
		holds_served = 0;
		value_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holds_served != holds_asked) begin
				holds_served++;
				repeat (HOLD_CYCLES) begin
					value_ch.ready <= 1'b0;
					@(posedge clk);
				end
			end
			value_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// one body byte, valid left high after the transfer so the next byte can follow
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			body_ch.valid <= 1'b0;
			@(posedge clk);
		end
		body_ch.valid     <= 1'b1;
		body_ch.body_byte <= b;
		body_ch.body_end  <= last;
		@(posedge clk);
		while (!body_ch.ready) @(posedge clk);
	endtask

	task automatic send_form(inout int unsigned count);
		int i;
		for (i = 0; i < form_bytes.size(); i++)
			send_byte(form_bytes[i], i == form_bytes.size() - 1);
		count += form_bytes.size();
	endtask

	// sender pause until every expected result has come back
	task automatic wait_results();
		body_ch.valid <= 1'b0;
		do @(posedge clk); while (board.waiting() != 0);
		repeat (4) @(posedge clk);
	endtask

	// all three registers, back to back with the enable held high
	task automatic load_settings(input logic [63:0] kt, input logic [3:0] kl,
		input logic [6:0] vl);
		wr_en    <= 1'b1;
		wr_index <= REG_KEY_TEXT;
		wr_data  <= kt;
		@(posedge clk);
		wr_index <= REG_KEY_LENGTH;
		wr_data  <= {60'd0, kl};
		@(posedge clk);
		wr_index <= REG_VALUE_LIMIT;
		wr_data  <= {57'd0, vl};
		@(posedge clk);
		wr_en    <= 1'b0;
		board.set_config(kt, kl, vl);
		cur_key = kt;
		cur_len = kl;
	endtask

	function automatic logic [63:0] pick_key();
		logic [63:0] k;
		int i;
		for (i = 0; i < 8; i++) begin
			case ($urandom_range(7))
				0:       k[8*i +: 8] = 8'h00;
				1:       k[8*i +: 8] = 8'hFF;
				2:       k[8*i +: 8] = 8'($urandom_range(255));
				default: k[8*i +: 8] = 8'(8'h61 + $urandom_range(25));
			endcase
		end
		return k;
	endfunction

	function automatic logic [7:0] pick_hex();
		int r;
		r = $urandom_range(21);
		if (r < 10) return 8'(8'h30 + r);
		if (r < 16) return 8'(8'h61 + r - 10);
		return 8'(8'h41 + r - 16);
	endfunction

	// value characters lean toward escapes and their edge cases
	function automatic logic [7:0] pick_value_char();
		case ($urandom_range(11))
			0:       return CH_PLUS;
			1, 2:    return CH_PCT;
			3, 4, 5: return pick_hex();
			6: begin
				// just outside the hex digit ranges
				case ($urandom_range(5))
					0:       return 8'h2F;
					1:       return 8'h3A;
					2:       return 8'h40;
					3:       return 8'h47;
					4:       return 8'h60;
					default: return 8'h67;
				endcase
			end
			7:       return 8'($urandom_range(255));
			default: return 8'($urandom_range(8'h27, 8'h7E));
		endcase
	endfunction

	// a body of one to four fields: mostly key=value, some near misses and junk,
	// sometimes cut short anywhere
	function automatic void build_form(bit long_value);
		int nseg, seg, kind, n, len, klen, cut;
		form_bytes.delete();
		klen = (cur_len > 8) ? 8 : cur_len;
		nseg = $urandom_range(1, 4);
		for (seg = 0; seg < nseg; seg++) begin
			if (seg > 0) form_bytes.push_back(CH_AMP);
			kind = (long_value && seg == 0) ? 0 : $urandom_range(9);
			if (kind < 5) begin
				for (n = 0; n < klen; n++) form_bytes.push_back(cur_key[8*n +: 8]);
				form_bytes.push_back(CH_EQ);
				len = (long_value && seg == 0) ? $urandom_range(126, 134) : $urandom_range(0, 12);
				repeat (len) form_bytes.push_back(pick_value_char());
			end else if (kind < 8) begin
				// key prefix, then a byte that most likely breaks the match
				len = $urandom_range(0, klen);
				for (n = 0; n < len; n++) form_bytes.push_back(cur_key[8*n +: 8]);
				form_bytes.push_back(8'($urandom_range(255)));
				repeat ($urandom_range(0, 4)) form_bytes.push_back(pick_value_char());
			end else begin
				repeat ($urandom_range(0, 6)) form_bytes.push_back(8'($urandom_range(255)));
			end
		end
		if ($urandom_range(6) == 0 && form_bytes.size() > 1) begin
			cut = $urandom_range(1, form_bytes.size());
			while (form_bytes.size() > cut) void'(form_bytes.pop_back());
		end
		if (form_bytes.size() == 0) form_bytes.push_back(8'($urandom_range(255)));
	endfunction

	initial begin
		int unsigned sent_rand;
		int unsigned phase_bytes;
		int unsigned dummy;
		int pidx;
		logic [63:0] kt;
		logic [3:0]  kl;
		logic [6:0]  vl;

		board = new();
		idle_pct    = 0;
		stall_pct   = 0;
		holds_asked = 0;
		cur_key     = KEY_TEXT_RST;
		cur_len     = KEY_LENGTH_RST;
		dummy       = 0;

		arst_n            <= 1'b0;
		wr_en             <= 1'b0;
		wr_index          <= REG_KEY_TEXT;
		wr_data           <= 64'd0;
		body_ch.valid     <= 1'b0;
		body_ch.body_byte <= 8'h00;
		body_ch.body_end  <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed, reset registers: key of four zero bytes, limit 32
		// plus, escape to 0xff, bad escape, escape cut short by the ampersand
		form_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, CH_EQ, CH_PLUS, CH_PCT, 8'h66, 8'h46,
			CH_PCT, 8'h7A, CH_PCT, 8'h34, CH_AMP};
		send_form(dummy);
		// body ends inside the key
		form_bytes = '{8'h00, 8'h00};
		send_form(dummy);
		// body ends on the equals sign: found, empty value
		form_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, CH_EQ};
		send_form(dummy);
		// last byte breaks a held escape: three bytes and the final result
		form_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, CH_EQ, CH_PCT, 8'h34, 8'h67};
		send_form(dummy);

		// random phases, each with its own registers and idling
		sent_rand = 0;
		for (pidx = 0; sent_rand < RAND_ITEMS; pidx++) begin
			wait_results();
			case (pidx)
				0: begin kt = pick_key(); kl = 4'd1; vl = 7'd127; end
				1: begin kt = pick_key(); kl = 4'd0; vl = 7'd0; end
				2: begin kt = '1; kl = 4'd8; vl = 7'd127; end
				3: begin kt = pick_key(); kl = 4'd15; vl = 7'($urandom_range(1, 6)); end
				4: begin
					// ampersand inside the key can never match
					kt = pick_key();
					kt[15:8] = CH_AMP;
					kl = 4'd3;
					vl = 7'd5;
				end
				default: begin
					kt = pick_key();
					kl = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
						: 4'($urandom_range(1, 8));
					case ($urandom_range(3))
						0:       vl = 7'd0;
						1:       vl = 7'd127;
						default: vl = 7'($urandom_range(1, 20));
					endcase
				end
			endcase
			load_settings(kt, kl, vl);

			case (pidx % 4)
				0:       begin idle_pct = 0;  stall_pct = 0;  end
				1:       begin idle_pct = 60; stall_pct = 0;  end
				2:       begin idle_pct = 0;  stall_pct = 60; end
				default: begin idle_pct = 29; stall_pct = 29; end
			endcase

			// receiver holds off while bytes keep coming, filling the block
			if (pidx == 0) holds_asked++;

			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES && sent_rand < RAND_ITEMS) begin
				// raw value of 126 to 134 bytes, most of them long enough to fill the buffer
				build_form((pidx == 2 || pidx == 3) && phase_bytes == 0);
				send_form(phase_bytes);
				sent_rand += form_bytes.size();
			end
		end

		wait_results();
		repeat (8) @(posedge clk);
		if (board.fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
